// ===== hdl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit page allocator
// Field widths, command and register codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int NUM_PAGES_DEF = 64;

    localparam int OWNER_W     = 8;
    localparam int SIZE_W      = 20;
    localparam int PAGE_SIZE_W = 16;
    localparam int PIU_W       = 7;
    localparam int FIRST_W     = 6;
    localparam int COUNT_W     = 7;
    // running sum stays below size limit plus one page size
    localparam int SUM_W       = 21;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = 16'd4096;
    localparam logic [PIU_W-1:0]       PIU_RST       = 7'd64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

    typedef struct packed {
        logic start_alloc;
        logic start_free;
        logic step_scan;
        logic step_free;
        logic push;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
        logic free_done;
        logic out_ready;
    } t_dp_status;

endpackage

// ===== hdl/ffpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ffpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ctrl: allocator sequencer
// Accepts a request, runs the allocate scan or the free sweep, hands result.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    output logic                  o_in_ready,
    input  ffpa_pkg::t_dp_status  i_status,
    output ffpa_pkg::t_ctrl_cmd   o_cmd
);
    import ffpa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FREE = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_FREE) begin
                        o_cmd.start_free = 1'b1;
                        n_state          = ST_FREE;
                    end else begin
                        o_cmd.start_alloc = 1'b1;
                        n_state           = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.step_scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_FREE: begin
                o_cmd.step_free = 1'b1;
                if (i_status.free_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== hdl/ffpa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_dp: allocator datapath
// Config registers, used bits, owner RAM, run scan, free sweep, output reg.
// ----------------------------------------------------------------------------
module ffpa_dp #(
    parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ffpa_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [ffpa_pkg::IN_DATA_W-1:0]      i_in_data,
    input  ffpa_pkg::t_ctrl_cmd                 i_cmd,
    output ffpa_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [ffpa_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import ffpa_pkg::*;

    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int CMP_W = (CNT_W > PIU_W) ? CNT_W : PIU_W;
    localparam logic [PIU_W-1:0] LIM_CAP = PIU_W'((NUM_PAGES < 127) ? NUM_PAGES : 127);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_PAGES);

    // configuration
    logic [PAGE_SIZE_W-1:0] r_page_size;
    logic [PIU_W-1:0]       r_pages_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size    <= PAGE_SIZE_RST;
            r_pages_in_use <= PIU_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_SIZE:    r_page_size    <= i_cfg_wdata[PAGE_SIZE_W-1:0];
                CFG_PAGES_IN_USE: r_pages_in_use <= i_cfg_wdata[PIU_W-1:0];
            endcase
        end
    end

    logic [PAGE_SIZE_W-1:0] w_ps;
    logic [PIU_W-1:0]       w_limit;

    assign w_ps    = (r_page_size == '0) ? PAGE_SIZE_W'(1) : r_page_size;
    assign w_limit = (r_pages_in_use > LIM_CAP) ? LIM_CAP : r_pages_in_use;

    // request
    logic [OWNER_W-1:0] r_owner;
    logic [SIZE_W-1:0]  r_size;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_alloc || i_cmd.start_free) begin
            r_owner <= i_in_data[OWNER_W-1:0];
            r_size  <= i_in_data[OWNER_W +: SIZE_W];
        end
    end

    // scan state
    logic [CNT_W-1:0]   r_idx;
    logic [CMP_W-1:0]   r_start;
    logic [COUNT_W-1:0] r_run;
    logic [SUM_W-1:0]   r_sum;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [NUM_PAGES-1:0] r_used;
    logic [NUM_PAGES-1:0] n_used;

    logic               w_scan_end;
    logic               w_page_used;
    logic [CMP_W-1:0]   w_start;
    logic [COUNT_W-1:0] w_run;
    logic [SUM_W-1:0]   w_sum;
    logic               w_found;
    logic               w_mark;
    logic               w_issue;
    logic [OWNER_W-1:0] w_rd_owner;
    logic               w_owner_we;

    assign w_scan_end  = CMP_W'(r_idx) >= CMP_W'(w_limit);
    assign w_page_used = r_used[r_idx[IDX_W-1:0]];
    assign w_start     = (r_run == '0) ? CMP_W'(r_idx) : r_start;
    assign w_run       = r_run + COUNT_W'(1);
    assign w_sum       = ((r_run == '0) ? SUM_W'(0) : r_sum) + SUM_W'(w_ps);
    assign w_found     = !w_scan_end && !w_page_used && (w_sum >= SUM_W'(r_size));
    assign w_mark      = i_cmd.step_scan && w_found && (r_size != '0);
    assign w_issue     = i_cmd.step_free && (r_idx != CNT_END);
    // owner is written ahead on every free page of the run; unused entries are ignored
    assign w_owner_we  = i_cmd.step_scan && !w_scan_end && !w_page_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_run    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (i_cmd.start_alloc || i_cmd.start_free) begin
                r_idx <= '0;
                r_run <= '0;
            end else if (i_cmd.step_scan && !w_scan_end) begin
                r_idx <= r_idx + CNT_W'(1);
                r_run <= w_page_used ? '0 : w_run;
            end else if (w_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[IDX_W-1:0];
        if (i_cmd.step_scan) begin
            r_start <= w_start;
            r_sum   <= w_sum;
        end
    end

    ffpa_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (NUM_PAGES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_owner_we),
        .i_waddr (r_idx[IDX_W-1:0]),
        .i_wdata (r_owner),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rd_owner)
    );

    // used bits
    always_comb begin
        n_used = r_used;
        if (w_mark) begin
            for (int k = 0; k < NUM_PAGES; k++) begin
                if (CMP_W'(k) >= w_start && CMP_W'(k) <= CMP_W'(r_idx)) begin
                    n_used[k] = 1'b1;
                end
            end
        end
        if (i_cmd.step_free && r_rd_vld && r_used[r_rd_idx] && (w_rd_owner == r_owner)) begin
            n_used[r_rd_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // result
    logic               r_res_ok;
    logic [FIRST_W-1:0] r_res_first;
    logic [COUNT_W-1:0] r_res_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_free) begin
            r_res_ok    <= 1'b1;
            r_res_first <= '0;
            r_res_count <= '0;
        end else if (i_cmd.step_scan) begin
            if (w_scan_end) begin
                r_res_ok    <= 1'b0;
                r_res_first <= '0;
                r_res_count <= '0;
            end else if (w_found) begin
                r_res_ok    <= 1'b1;
                r_res_first <= (r_size == '0) ? '0 : w_start[FIRST_W-1:0];
                r_res_count <= (r_size == '0) ? '0 : w_run;
            end
        end
    end

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= {(OUT_DATA_W - 1 - FIRST_W - COUNT_W)'(0),
                           r_res_count, r_res_first, r_res_ok};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.scan_done = w_scan_end || w_found;
    assign o_status.free_done = (r_idx == CNT_END) && !r_rd_vld;
    assign o_status.out_ready = !r_out_valid || i_out_ready;

endmodule

// ===== hdl/first_fit_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// Allocate: after the accept, pages are scanned in order until a fit is found or
//   min(pages_in_use, NUM_PAGES) is reached, then the result is loaded into the
//   output register once that register is empty or being read.
// Free: one owner RAM read per page over all NUM_PAGES.
// One request at a time; the next is accepted while the last result waits.
// Synchronous active-low reset frees every page and restores the registers.
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit: first-fit contiguous page allocator
// Owner table of equal pages; allocate a lowest free run, free by owner.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_unit #(
    parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ffpa_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ffpa_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // owner_id, request_size
    input  logic                                s_axis_tuser,  // cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ffpa_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // ok, first_page, page_count
);
    import ffpa_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    ffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ffpa_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/ffpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_checker: port-level checks of the page allocator
// Result timing, failure encoding and output hold; bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_checker #(
    parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [ffpa_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import ffpa_pkg::*;

    logic w_s_xfer;

    assign w_s_xfer = s_axis_tvalid && s_axis_tready;

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer |=> !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("request not held busy after transfer");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |->
            (m_axis_tdata[FIRST_W + COUNT_W:1] == '0))
        else $error("failed allocation reports nonzero page fields");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (32'(m_axis_tdata[FIRST_W + COUNT_W:FIRST_W + 1]) <= NUM_PAGES))
        else $error("page count beyond table");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind first_fit_page_allocator_unit ffpa_checker #(
    .NUM_PAGES (NUM_PAGES)
) u_ffpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for first_fit_page_allocator_unit
// Directed and random allocate/free requests go in over the stream ports, with
// random gaps and back-pressure on both sides. An in-bench owner-table model
// predicts every result, and each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import ffpa_pkg::*;

    localparam int          NPAGES     = NUM_PAGES_DEF;
    localparam int          IDLE_LIMIT = 4000;
    localparam int unsigned SIZE_MAX   = (1 << SIZE_W) - 1;

    typedef struct packed {
        logic               ok;
        logic [FIRST_W-1:0] first_pg;
        logic [COUNT_W-1:0] pg_count;
    } t_alloc_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // owner_id, request_size
    logic                  s_axis_tuser  = 1'b0; // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // ok, first_page, page_count

    // owner table model
    logic                   page_taken  [NPAGES];
    logic [OWNER_W-1:0]     page_holder [NPAGES];
    logic [PAGE_SIZE_W-1:0] cur_page_size;
    logic [PIU_W-1:0]       cur_pages_live;

    t_alloc_result pending_results[$];
    int            err_cnt     = 0;
    int            idle_cycles = 0;
    int            stall_left  = 0;
    bit            tx_calm     = 1'b0;
    bit            rx_calm     = 1'b0;

    first_fit_page_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // size that needs exactly the given number of pages at the current page size, or all ones if none fits
    function automatic logic [SIZE_W-1:0] size_for_pages(input int unsigned pages);
        int unsigned ps;
        int unsigned lo;
        int unsigned hi;
        ps = (cur_page_size == 0) ? 1 : cur_page_size;
        lo = (pages - 1) * ps + 1;
        hi = pages * ps;
        if (hi > SIZE_MAX)
            hi = SIZE_MAX;
        if (lo > hi)
            return '1;
        return SIZE_W'($urandom_range(hi, lo));
    endfunction

    task automatic predict_request(input logic cmd, input logic [OWNER_W-1:0] owner,
                                   input logic [SIZE_W-1:0] size, output t_alloc_result r);
        int unsigned ps;
        int unsigned lim;
        int unsigned need;
        int unsigned run;
        int unsigned start;
        bit          found;
        r = '0;
        if (cmd == CMD_FREE) begin
            // releases pages beyond the scan limit too
            for (int i = 0; i < NPAGES; i++) begin
                if (page_taken[i] && page_holder[i] == owner)
                    page_taken[i] = 1'b0;
            end
            r.ok = 1'b1;
            return;
        end
        ps   = (cur_page_size == 0) ? 1 : cur_page_size;
        lim  = (cur_pages_live > NPAGES) ? NPAGES : cur_pages_live;
        need = (size + ps - 1) / ps;
        if (need == 0) begin
            for (int i = 0; i < lim; i++) begin
                if (!page_taken[i])
                    r.ok = 1'b1;
            end
            return;
        end
        run   = 0;
        start = 0;
        found = 1'b0;
        for (int i = 0; i < lim && !found; i++) begin
            if (page_taken[i]) begin
                run = 0;
            end else begin
                if (run == 0)
                    start = i;
                run++;
                if (run >= need)
                    found = 1'b1;
            end
        end
        if (found) begin
            for (int j = start; j < start + need; j++) begin
                page_taken[j]  = 1'b1;
                page_holder[j] = owner;
            end
            r.ok       = 1'b1;
            r.first_pg = start[FIRST_W-1:0];
            r.pg_count = need[COUNT_W-1:0];
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    task automatic send_request(input logic cmd, input logic [OWNER_W-1:0] owner,
                                input logic [SIZE_W-1:0] size);
        int            gap;
        t_alloc_result r;
        gap = tx_calm ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {{(IN_DATA_W - OWNER_W - SIZE_W){1'b0}}, size, owner};
        s_axis_tuser  = cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(cmd, owner, size, r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // sender holds off until every pending result is back
    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle_block();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_PAGE_SIZE)
            cur_page_size = val;
        else
            cur_pages_live = val[PIU_W-1:0];
    endtask

    task automatic send_random_request();
        int                 pick;
        int unsigned        pages;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
        pick = $urandom_range(0, 99);
        // mostly a small owner set so frees hit held pages
        if ($urandom_range(0, 99) < 85)
            owner = OWNER_W'($urandom_range(0, 5) * 51);
        else
            owner = OWNER_W'($urandom_range(0, 255));
        if (pick < 30) begin
            send_request(CMD_FREE, owner, SIZE_W'($urandom));
        end else begin
            if (pick < 36) begin
                size = SIZE_W'($urandom);
            end else if (pick < 40) begin
                size = '0;
            end else begin
                if ($urandom_range(0, 9) == 0)
                    pages = $urandom_range(13, 64);
                else
                    pages = $urandom_range(1, 12);
                size = size_for_pages(pages);
            end
            send_request(CMD_ALLOC, owner, size);
        end
    endtask

    // first fit, hole reuse, oversized and zero-size requests, full table
    task automatic test_fit_and_release();
        send_request(CMD_ALLOC, 8'h00, 20'd0);
        send_request(CMD_ALLOC, 8'hFF, 20'd1);
        send_request(CMD_ALLOC, 8'h01, 20'd4096);
        send_request(CMD_ALLOC, 8'h02, 20'd4097);
        send_request(CMD_ALLOC, 8'hAA, 20'hFFFFF);
        send_request(CMD_FREE,  8'h01, 20'hFFFFF);
        send_request(CMD_ALLOC, 8'h55, 20'd8192);
        send_request(CMD_ALLOC, 8'h03, 20'd4096);
        send_request(CMD_FREE,  8'h77, 20'd0);
        send_request(CMD_ALLOC, 8'h10, 20'd237568);
        send_request(CMD_ALLOC, 8'h20, 20'd0);
        send_request(CMD_ALLOC, 8'h20, 20'd1);
    endtask

    task automatic test_page_size_limits();
        write_reg(CFG_PAGE_SIZE, 16'd0);
        send_request(CMD_FREE,  8'h10, 20'd0);
        send_request(CMD_ALLOC, 8'h21, 20'd3);
        write_reg(CFG_PAGE_SIZE, 16'hFFFF);
        send_request(CMD_ALLOC, 8'h22, 20'hFFFFF);
        write_reg(CFG_PAGE_SIZE, 16'd1);
        send_request(CMD_ALLOC, 8'h23, 20'd1);
    endtask

    task automatic test_pages_in_use_limits();
        write_reg(CFG_PAGES_IN_USE, 16'd0);
        send_request(CMD_ALLOC, 8'h24, 20'd0);
        send_request(CMD_ALLOC, 8'h24, 20'd1);
        write_reg(CFG_PAGES_IN_USE, 16'd127);
        send_request(CMD_ALLOC, 8'h25, 20'd37);
        // pages above the limit must still be released
        write_reg(CFG_PAGES_IN_USE, 16'd8);
        send_request(CMD_FREE,  8'h25, 20'd0);
        send_request(CMD_ALLOC, 8'h26, 20'd1);
        send_request(CMD_ALLOC, 8'h26, 20'd0);
        write_reg(CFG_PAGES_IN_USE, 16'd64);
        send_request(CMD_ALLOC, 8'h26, 20'd38);
        send_request(CMD_ALLOC, 8'h26, 20'd37);
    endtask

    task automatic test_random_traffic();
        logic [PAGE_SIZE_W-1:0] ps;
        logic [PIU_W-1:0]       piu;
        int                     n;
        for (int ph = 0; ph < 8; ph++) begin
            n = 145;
            case (ph)
                0: begin
                    ps  = 16'd4096;
                    piu = 7'd64;
                end
                1: begin
                    ps  = 16'd1;
                    piu = 7'd64;
                end
                2: begin
                    ps  = 16'hFFFF;
                    piu = 7'd40;
                end
                3: begin
                    ps  = 16'd0;
                    piu = 7'd127;
                end
                4: begin
                    ps  = PAGE_SIZE_W'($urandom_range(2, 5000));
                    piu = 7'd1;
                end
                5: begin
                    ps  = PAGE_SIZE_W'($urandom_range(1, 16'hFFFF));
                    piu = 7'd0;
                    n   = 40;
                end
                6: begin
                    ps  = PAGE_SIZE_W'($urandom_range(1, 16'hFFFF));
                    piu = PIU_W'($urandom_range(1, 64));
                end
                default: begin
                    ps  = PAGE_SIZE_W'($urandom_range(1, 20000));
                    piu = PIU_W'($urandom_range(65, 127));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_PAGE_SIZE, ps);
                write_reg(CFG_PAGES_IN_USE, CFG_DATA_W'(piu));
            end else begin
                write_reg(CFG_PAGES_IN_USE, CFG_DATA_W'(piu));
                write_reg(CFG_PAGE_SIZE, ps);
            end
            for (int k = 0; k < n; k++) begin
                if (k % 50 == 0) begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                send_random_request();
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            m_axis_tready = 1'b0;
            stall_left    = pick_gap();
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_axis_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.ok)
                    report_mismatch("ok", int'(m_axis_tdata[0]), int'(want.ok));
                if (m_axis_tdata[FIRST_W:1] !== want.first_pg)
                    report_mismatch("first_page", int'(m_axis_tdata[FIRST_W:1]),
                                    int'(want.first_pg));
                if (m_axis_tdata[FIRST_W+COUNT_W:FIRST_W+1] !== want.pg_count)
                    report_mismatch("page_count",
                                    int'(m_axis_tdata[FIRST_W+COUNT_W:FIRST_W+1]),
                                    int'(want.pg_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NPAGES; i++)
            page_taken[i] = 1'b0;
        cur_page_size  = PAGE_SIZE_RST;
        cur_pages_live = PIU_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fit_and_release();
        test_page_size_limits();
        test_pages_in_use_limits();
        test_random_traffic();

        settle_block();
        repeat (NPAGES + 8) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
